// ===== sv/ikxd_pkg.sv =====
// ============================================================================
// ikxd_pkg - shared types and constants for the keystream XOR decryptor
// Register indexes, mixing constants and the controller-to-datapath
// command bundle.
// ============================================================================
package ikxd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN     = 3'd4;

  // Mixing constants
  localparam logic [31:0] GOLDEN_MUL = 32'h9e3779b9;
  localparam logic [31:0] ROT_OFFSET = 32'h6d2b79f5;
  localparam logic [31:0] FIN_MUL_A  = 32'h7feb352d;
  localparam logic [31:0] FIN_MUL_B  = 32'h846ca68b;

  // Key byte offsets for the gathered word; multiplier and offset for the final whitening byte
  localparam logic [4:0] GATHER_OFS_1 = 5'd7;
  localparam logic [4:0] GATHER_OFS_2 = 5'd13;
  localparam logic [4:0] GATHER_OFS_3 = 5'd21;
  localparam logic [7:0] WHITEN_MUL   = 8'd5;
  localparam logic [7:0] WHITEN_OFS   = 8'd11;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // beat accepted: capture byte, pick index
    logic mix;     // form the pre-finaliser word
    logic av1;     // first shift-xor and multiply
    logic av2;     // second shift-xor and multiply
    logic fin;     // last shift-xor, byte select, load output register
  } ikxd_cmd_t;

endpackage

// ===== sv/ikxd_ctrl.sv =====
// ============================================================================
// ikxd_ctrl - sequencing controller
// Walks one beat through the datapath steps and owns the output valid.
// ============================================================================
module ikxd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ikxd_pkg::ikxd_cmd_t cmd
);
  import ikxd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_AV1,
    S_AV2,
    S_FIN
  } state_t;

  state_t state;
  logic   fin_go;

  // Output register may be loaded when empty or being drained this cycle
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  // Commands decoded from state
  always_comb begin
    cmd      = '0;
    cmd.load = in_valid && in_ready;
    cmd.mix  = (state == S_MIX);
    cmd.av1  = (state == S_AV1);
    cmd.av2  = (state == S_AV2);
    cmd.fin  = fin_go;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_MIX;
        S_MIX:  state <= S_AV1;
        S_AV1:  state <= S_AV2;
        S_AV2:  state <= S_FIN;
        S_FIN:  if (fin_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/ikxd_datapath.sv =====
// ============================================================================
// ikxd_datapath - key store, byte index and keystream arithmetic
// At most one 32x32 multiply per step; each step result is registered.
// ============================================================================
module ikxd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ikxd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ikxd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                          cipher_byte,
  input  logic                                block_start,
  input  ikxd_pkg::ikxd_cmd_t                 cmd,
  output logic [7:0]                          plain_byte
);
  import ikxd_pkg::*;

  logic [255:0] key;
  logic [31:0]  domain_word;
  logic [31:0]  byte_index;

  logic [31:0]  n_cur;
  logic [7:0]   cipher;
  logic [31:0]  x_mix;
  logic [31:0]  x_av1;
  logic [31:0]  x_av2;

  logic [31:0]  n_sel;
  logic [4:0]   p0, p1, p2, p3, pw;
  logic [31:0]  gathered;
  logic [31:0]  golden;
  logic [31:0]  rot_in;
  logic [4:0]   rot_amt;
  logic [63:0]  rot_wide;
  logic [31:0]  mix_next;
  logic [31:0]  sx1, sx2, sx3;
  logic [31:0]  av1_next, av2_next;
  logic [7:0]   ks_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key         <= '0;
      domain_word <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_WORD_0: key[63:0]    <= cfg_data;
        REG_KEY_WORD_1: key[127:64]  <= cfg_data;
        REG_KEY_WORD_2: key[191:128] <= cfg_data;
        REG_KEY_WORD_3: key[255:192] <= cfg_data;
        REG_DOMAIN:     domain_word  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Index of this beat: block start forces zero
  assign n_sel = block_start ? 32'd0 : byte_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (cmd.load) begin
      byte_index <= n_sel + 32'd1;
    end
  end

  // Key byte positions, all mod 32
  assign p0 = n_cur[4:0];
  assign p1 = n_cur[4:0] + GATHER_OFS_1;
  assign p2 = n_cur[4:0] + GATHER_OFS_2;
  assign p3 = n_cur[4:0] + GATHER_OFS_3;
  assign pw = 5'(({3'b000, n_cur[4:0]} * WHITEN_MUL) + WHITEN_OFS);

  assign gathered = {key[{p3, 3'b000} +: 8], key[{p2, 3'b000} +: 8],
                     key[{p1, 3'b000} +: 8], key[{p0, 3'b000} +: 8]};

  // Mix step: golden product, rotated offset, key and domain
  assign golden   = n_cur * GOLDEN_MUL;
  assign rot_in   = n_cur + ROT_OFFSET;
  assign rot_amt  = {1'b0, n_cur[3:0]} + 5'd1;
  assign rot_wide = {rot_in, rot_in} << rot_amt;
  assign mix_next = domain_word ^ golden ^ gathered ^ rot_wide[63:32];

  // Finaliser steps
  assign sx1      = x_mix ^ (x_mix >> 16);
  assign av1_next = sx1 * FIN_MUL_A;
  assign sx2      = x_av1 ^ (x_av1 >> 15);
  assign av2_next = sx2 * FIN_MUL_B;
  assign sx3      = x_av2 ^ (x_av2 >> 16);
  assign ks_byte  = sx3[{n_cur[1:0], 3'b000} +: 8] ^ key[{pw, 3'b000} +: 8];

  // Datapath registers (payload only, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_cur  <= n_sel;
      cipher <= cipher_byte;
    end
    if (cmd.mix) x_mix <= mix_next;
    if (cmd.av1) x_av1 <= av1_next;
    if (cmd.av2) x_av2 <= av2_next;
    if (cmd.fin) plain_byte <= cipher ^ ks_byte;
  end

endmodule

// ===== sv/indexed_keystream_xor_decrypt_top.sv =====
// ============================================================================
// indexed_keystream_xor_decrypt_top - keyed byte-stream decryptor
// XORs each ciphertext byte with a keystream byte derived from the key,
// the domain word and a running byte index.
// ============================================================================
//  Channel | Direction | Signals                            | Handshake
//  --------+-----------+------------------------------------+-----------------
//  in      | input     | cipher_byte, block_start           | in_valid/in_ready
//  out     | output    | plain_byte                         | out_valid/out_ready
//  cfg     | input     | cfg_index, cfg_data                | cfg_write only
//
//  Each beat goes through capture, mix, two finaliser multiplies and the
//  byte select, with at most one 32x32 multiply per step in the datapath.
//  The output register holds a result while the next beat is accepted.
//  A stalled output holds the last step until the register drains.
//  Synchronous reset clears the key, domain word and byte index to zero.
// ============================================================================
module indexed_keystream_xor_decrypt_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ikxd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ikxd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      cipher_byte,
  input  logic                            block_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      plain_byte
);
  import ikxd_pkg::*;

  ikxd_cmd_t cmd;

  ikxd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ikxd_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cipher_byte (cipher_byte),
    .block_start (block_start),
    .cmd         (cmd),
    .plain_byte  (plain_byte)
  );

endmodule

// ===== sv/ikxd_checker.sv =====
// ============================================================================
// ikxd_checker - port-level checks for the decryptor
// Watches the handshakes and beat sequencing seen at the top level.
// ============================================================================
module ikxd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] plain_byte
);

  // A waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the beat was taken");

  // A waiting result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(plain_byte))
    else $error("plain_byte changed while stalled");

  // One beat in flight: input closed right after an accept
  a_busy_next: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a beat is in flight");

  // Input is still closed when the final step of the computation is reached
  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##4 !in_ready)
    else $error("input reopened before the result was formed");

  // A new result appears only at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a beat being processed");

endmodule

bind indexed_keystream_xor_decrypt_top ikxd_checker u_ikxd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .plain_byte (plain_byte)
);

// ===== sim/indexed_keystream_xor_decrypt_top_tb.sv =====
// ============================================================================
// indexed_keystream_xor_decrypt_top_tb - self-checking bench for the decryptor
// Drives ciphertext beats with random gaps and random output back-pressure.
// Each accepted beat is predicted from a shadow copy of the key, domain word
// and byte index. Every plain_byte beat is compared in order against the
// predictions. The key is reprogrammed between phases with zeros, ones and
// random words.
// ============================================================================
`timescale 1ns / 1ps

module indexed_keystream_xor_decrypt_top_tb;
  import ikxd_pkg::*;

  // Register indexes the block does not decode; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 125;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            cipher_byte;
  logic                  block_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            plain_byte;

  // Shadow state of the block
  logic [63:0] key_shadow [4];
  logic [31:0] domain_shadow;
  logic [31:0] stream_index;

  logic [7:0]            expected_plain [$];
  logic [CFG_IDX_W-1:0]  pending_idx [$];
  logic [CFG_DATA_W-1:0] pending_data [$];

  int unsigned mismatches;
  int unsigned cycles;
  int          ready_hold;
  bit          full_speed;
  logic [7:0]  want;

  indexed_keystream_xor_decrypt_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cipher_byte (cipher_byte),
    .block_start (block_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .plain_byte  (plain_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Keystream prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] key_byte(input logic [4:0] pos);
    return key_shadow[pos[4:3]][{pos[2:0], 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] keystream_byte(input logic [31:0] n);
    logic [31:0] gathered;
    logic [31:0] offset;
    logic [31:0] rotated;
    logic [31:0] x;
    logic [31:0] whiten_pos;
    int          amount;
    gathered = {key_byte(n[4:0] + GATHER_OFS_3), key_byte(n[4:0] + GATHER_OFS_2),
                key_byte(n[4:0] + GATHER_OFS_1), key_byte(n[4:0])};
    // rotate amount is 1..16, so never a plain pass-through
    offset  = n + ROT_OFFSET;
    amount  = int'(n[3:0]) + 1;
    rotated = (offset << amount) | (offset >> (32 - amount));
    x = domain_shadow ^ (n * GOLDEN_MUL) ^ gathered ^ rotated;
    // finaliser
    x = x ^ (x >> 16);
    x = x * FIN_MUL_A;
    x = x ^ (x >> 15);
    x = x * FIN_MUL_B;
    x = x ^ (x >> 16);
    whiten_pos = n * 32'(WHITEN_MUL) + 32'(WHITEN_OFS);
    return x[{n[1:0], 3'b000} +: 8] ^ key_byte(whiten_pos[4:0]);
  endfunction

  // Mostly short gaps, the odd long one; none at all in full-speed stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (full_speed || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    $display("[%0d] mismatch on %s: expected %02h, got %02h", cycles, what, exp_v, got_v);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic s);
    int          gap;
    logic [31:0] n;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cipher_byte <= c;
    block_start <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    // beat accepted: advance the shadow index
    if (s) stream_index = '0;
    n = stream_index;
    expected_plain.push_back(c ^ keystream_byte(n));
    stream_index = n + 32'd1;
  endtask

  // Let every outstanding beat come back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_plain.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    pending_idx.push_back(idx);
    pending_data.push_back(d);
  endtask

  // Back-to-back writes with the enable held high, shadow updated per edge
  task automatic flush_writes();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] d;
    while (pending_idx.size() != 0) begin
      idx = pending_idx.pop_front();
      d   = pending_data.pop_front();
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      @(posedge clk);
      case (idx)
        REG_KEY_WORD_0: key_shadow[0] = d;
        REG_KEY_WORD_1: key_shadow[1] = d;
        REG_KEY_WORD_2: key_shadow[2] = d;
        REG_KEY_WORD_3: key_shadow[3] = d;
        REG_DOMAIN:     domain_shadow = d[31:0];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  task automatic program_all(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] dom);
    queue_write(REG_KEY_WORD_0, k0);
    queue_write(REG_KEY_WORD_1, k1);
    queue_write(REG_KEY_WORD_2, k2);
    queue_write(REG_KEY_WORD_3, k3);
    queue_write(REG_DOMAIN, dom);
    flush_writes();
  endtask

  function automatic logic [63:0] rand_word(input int kind);
    case (kind)
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset key and domain are zero; first beat uses index 0 even without a start
  task automatic test_zero_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_byte(8'ha5, 1'b0);
    drain();
  endtask

  // All-ones key; domain written with its upper bits set, which must be ignored
  task automatic test_all_ones();
    program_all('1, '1, '1, '1, '1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b0);
    drain();
  endtask

  // Block start mid-stream and on consecutive beats
  task automatic test_block_start();
    program_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                64'h1716151413121110, 64'h1f1e1d1c1b1a1918, 64'h00000000_deadbeef);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    send_byte(8'h55, 1'b1);
    send_byte(8'h66, 1'b0);
    drain();
  endtask

  // Key rewritten inside a block: index carries on from where it was
  task automatic test_rewrite_mid_block();
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    drain();
    program_all(rand_word(2), rand_word(2), rand_word(2), rand_word(2), rand_word(2));
    send_byte(8'hfe, 1'b0);
    send_byte(8'h7f, 1'b0);
    drain();
  endtask

  // Writes to undecoded indexes leave every register alone
  task automatic test_unknown_index();
    queue_write(REG_SPARE_5, rand_word(2));
    queue_write(REG_SPARE_6, '1);
    queue_write(REG_SPARE_7, rand_word(2));
    flush_writes();
    send_byte(8'h3c, 1'b0);
    send_byte(8'hc3, 1'b1);
    drain();
  endtask

  // Random streams: blocks of varied length, key reprogrammed between phases
  task automatic test_random_stream();
    int          run_left;
    int          kind;
    logic        s;
    run_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      kind = $urandom_range(0, 3);
      // a stray write to a spare index goes out ahead of the real ones
      if ($urandom_range(0, 1) == 1) begin
        queue_write(REG_SPARE_5 + CFG_IDX_W'($urandom_range(0, 2)), rand_word(2));
      end
      program_all(rand_word(kind), rand_word(kind == 0 ? 2 : kind),
                  rand_word($urandom_range(0, 3)), rand_word(kind),
                  rand_word($urandom_range(0, 2)));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i % 40 == 0) full_speed = ($urandom_range(0, 3) == 0);
        // most blocks short, some long enough to lap the key several times
        if (run_left == 0) begin
          s = 1'b1;
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 40);
        end else begin
          s = ($urandom_range(0, 49) == 0);
        end
        run_left--;
        send_byte(8'($urandom), s);
      end
      full_speed = 1'b0;
      drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and output back-pressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_plain.size() == 0) begin
        report_mismatch("unexpected plain_byte beat", 8'h00, plain_byte);
      end else begin
        want = expected_plain.pop_front();
        if (plain_byte !== want) report_mismatch("plain_byte", want, plain_byte);
      end
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches    = 0;
    cycles        = 0;
    ready_hold    = 0;
    full_speed    = 1'b0;
    key_shadow[0] = '0;
    key_shadow[1] = '0;
    key_shadow[2] = '0;
    key_shadow[3] = '0;
    domain_shadow = '0;
    stream_index  = '0;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cipher_byte <= '0;
    block_start <= 1'b0;
    out_ready   <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_key();
    test_all_ones();
    test_block_start();
    test_rewrite_mid_block();
    test_unknown_index();
    test_random_stream();

    drain();
    if (mismatches == 0 && expected_plain.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ikxd_pkg.sv
sv/ikxd_ctrl.sv
sv/ikxd_datapath.sv
sv/indexed_keystream_xor_decrypt_top.sv
sv/ikxd_checker.sv
sim/indexed_keystream_xor_decrypt_top_tb.sv
